### hdl/assert_macros.svh
// Assertion macros shared by the RTL files.
// Clock clk_i and active-low reset rst_ni are taken from the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge, off while in reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication checked in the same cycle.
`define ASSERT_IMPL(label, ante, cons, msg) \
  `ASSERT_CLK(label, (ante) |-> (cons), msg)

// Implication whose consequent is checked in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
  `ASSERT_CLK(label, (ante) |=> (cons), msg)

`endif

### hdl/strm_pkg.sv
// Shared types and constants of the sparse-table range-minimum block.
// No dependencies.
package strm_pkg;

  localparam int CMD_W   = 2;
  localparam int IDX_W   = 10;
  localparam int CNT_W   = 11;
  localparam int DATA_W  = 64;
  // wide enough for any position sum at the largest parameter values
  localparam int CMP_W   = 18;

  localparam logic [CNT_W-1:0] CNT_RESET = 11'd1024;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD  = 2'd0,
    CMD_BUILD = 2'd1,
    CMD_QUERY = 2'd2
  } cmd_e;

  // build sequencer status toward the table owner
  typedef struct packed {
    logic busy;
    logic rd_en;
    logic wr_en;
  } bld_ctl_t;

endpackage

### hdl/strm_build.sv
// Build sequencer: walks levels 1..LEVELS-1, one read pair per cycle within a level.
// Depends on strm_pkg; the table itself lives in the top level.
module strm_build #(
  parameter int LEVELS = 11,
  parameter int IDX_W  = 10,
  parameter int LVL_W  = 4
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic                       drained_i,
  input  logic [strm_pkg::CMP_W-1:0] live_cnt_i,
  output strm_pkg::bld_ctl_t         ctl_o,
  output logic [LVL_W-1:0]           rd_lvl_o,
  output logic [IDX_W-1:0]           rd_pos_a_o,
  output logic [IDX_W-1:0]           rd_pos_b_o,
  output logic [LVL_W-1:0]           wr_lvl_o,
  output logic [IDX_W-1:0]           wr_pos_o
);

  typedef enum logic [1:0] {
    B_IDLE,
    B_DRAIN,
    B_RUN
  } bstate_e;

  bstate_e                    state_q;
  logic [LVL_W-1:0]           k_q;
  logic [IDX_W:0]             j_q;
  logic                       wr_v_q;
  logic [IDX_W-1:0]           wr_pos_q;
  logic [strm_pkg::CMP_W-1:0] half;
  logic [strm_pkg::CMP_W-1:0] pos_b;
  logic                       go;

  assign half  = strm_pkg::CMP_W'(1) << (k_q - LVL_W'(1));
  assign pos_b = strm_pkg::CMP_W'(j_q) + half;
  assign go    = (state_q == B_RUN) && (pos_b < live_cnt_i);

  // A level's last write lands while go is low between levels, before the next
  // level's first read, so that read always sees it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= B_IDLE;
      k_q      <= LVL_W'(1);
      j_q      <= '0;
      wr_v_q   <= 1'b0;
      wr_pos_q <= '0;
    end else begin
      case (state_q)
        B_IDLE: begin
          wr_v_q <= 1'b0;
          if (start_i && LEVELS > 1) begin
            state_q <= B_DRAIN;
            k_q     <= LVL_W'(1);
            j_q     <= '0;
          end
        end
        B_DRAIN: begin
          if (drained_i) begin
            state_q <= B_RUN;
          end
        end
        B_RUN: begin
          if (go) begin
            wr_v_q   <= 1'b1;
            wr_pos_q <= j_q[IDX_W-1:0];
            j_q      <= j_q + 1'b1;
          end else begin
            wr_v_q <= 1'b0;
            j_q    <= '0;
            if (k_q == LVL_W'(LEVELS - 1)) begin
              state_q <= B_IDLE;
            end else begin
              k_q <= k_q + 1'b1;
            end
          end
        end
        default: begin
          state_q <= B_IDLE;
        end
      endcase
    end
  end

  assign ctl_o.busy  = (state_q != B_IDLE);
  assign ctl_o.rd_en = go;
  assign ctl_o.wr_en = wr_v_q;
  assign rd_lvl_o    = k_q - LVL_W'(1);
  assign rd_pos_a_o  = j_q[IDX_W-1:0];
  assign rd_pos_b_o  = pos_b[IDX_W-1:0];
  assign wr_lvl_o    = k_q;
  assign wr_pos_o    = wr_pos_q;

endmodule

### hdl/sparse_table_range_minimum.sv
// Top level of the sparse-table range-minimum block: table memory, query path.
// Depends on strm_pkg, strm_build and assert_macros.svh.
//
// Usage: one input channel (in_valid_i/in_ready_o) carries a command word:
// load writes one element of level 0, build fills all upper levels, query
// returns the minimum over [range_low_i, range_high_i]. Only queries send a
// word on the output channel (out_valid_o/out_ready_i); a bad range gives
// range_error_o = 1 and minimum_o = 0. cfg_we_i/cfg_wdata_i set the element
// count, which the user must write only while the block is idle; the block does not enforce this.
// Loads and queries are taken one per cycle while no build runs and the output
// is not stalled. A query word reaches the output through the read stage and
// the output register: the synchronous table read is registered at the accepting
// edge, and the compare lands in the output register once the output advances.
// A build waits for the query read stage to empty, then writes each upper-level
// entry in turn, level by level, through the single write port.
// Input is held off for the whole build.
// If the receiver stalls, one finished word waits in the output register and
// one more in the read stage; input then stops.
// Reset clears control and sets the count to 1024; table contents are
// undefined until loaded and built.
`include "assert_macros.svh"

module sparse_table_range_minimum #(
  parameter int MAX_ENTRIES = 1024,
  parameter int LEVELS      = 11,
  parameter int VALUE_WIDTH = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [strm_pkg::CMD_W-1:0]  cmd_i,
  input  logic [strm_pkg::IDX_W-1:0]  load_index_i,
  input  logic signed [strm_pkg::DATA_W-1:0] load_value_i,
  input  logic [strm_pkg::IDX_W-1:0]  range_low_i,
  input  logic [strm_pkg::IDX_W-1:0]  range_high_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic signed [strm_pkg::DATA_W-1:0] minimum_o,
  output logic                        range_error_o,
  input  logic                        cfg_we_i,
  input  logic [strm_pkg::CNT_W-1:0]  cfg_wdata_i
);

  localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int LVL_W = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int AW    = LVL_W + IDX_W;
  localparam int DEPTH = LEVELS * (1 << IDX_W);
  localparam int CW    = strm_pkg::CMP_W;
  localparam int LEN_W = strm_pkg::IDX_W + 1;
  localparam int K_W   = $clog2(LEN_W);

  // configuration
  logic [strm_pkg::CNT_W-1:0] count_q;
  logic [CW-1:0]              live_cnt;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= strm_pkg::CNT_RESET;
    end else if (cfg_we_i) begin
      count_q <= cfg_wdata_i;
    end
  end

  assign live_cnt = (CW'(count_q) > CW'(MAX_ENTRIES)) ? CW'(MAX_ENTRIES) : CW'(count_q);

  // handshake and command decode
  logic     in_acc;
  logic     load_acc;
  logic     build_acc;
  logic     query_acc;
  logic     adv;
  logic     v1_q;
  logic     err1_q;
  logic     out_valid_q;
  logic signed [strm_pkg::DATA_W-1:0] minimum_q;
  logic     range_error_q;
  strm_pkg::bld_ctl_t bctl;

  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = !bctl.busy && (!v1_q || adv);
  assign in_acc     = in_valid_i && in_ready_o;
  assign load_acc   = in_acc && (cmd_i == strm_pkg::CMD_LOAD)
                      && (CW'(load_index_i) < CW'(MAX_ENTRIES));
  assign build_acc  = in_acc && (cmd_i == strm_pkg::CMD_BUILD);
  assign query_acc  = in_acc && (cmd_i == strm_pkg::CMD_QUERY);

  // query decode: error check, floor log2 of the length, block addresses
  logic [CW-1:0]    lo_w;
  logic [CW-1:0]    hi_w;
  logic             q_err;
  logic [LEN_W-1:0] q_len;
  logic [K_W-1:0]   q_log;
  logic [K_W-1:0]   q_k;
  logic [CW-1:0]    q_pos_b;

  assign lo_w  = CW'(range_low_i);
  assign hi_w  = CW'(range_high_i);
  assign q_err = (lo_w > hi_w) || (hi_w >= live_cnt);
  assign q_len = LEN_W'(range_high_i) - LEN_W'(range_low_i) + LEN_W'(1);

  always_comb begin
    q_log = '0;
    for (int i = 0; i < LEN_W; i++) begin
      if (q_len[i]) begin
        q_log = K_W'(i);
      end
    end
  end

  assign q_k     = (int'(q_log) > LEVELS - 1) ? K_W'(LEVELS - 1) : q_log;
  assign q_pos_b = hi_w - (CW'(1) << q_k) + CW'(1);

  // build sequencer
  logic [LVL_W-1:0] b_rd_lvl;
  logic [IDX_W-1:0] b_pos_a;
  logic [IDX_W-1:0] b_pos_b;
  logic [LVL_W-1:0] b_wr_lvl;
  logic [IDX_W-1:0] b_wr_pos;

  strm_build #(
    .LEVELS (LEVELS),
    .IDX_W  (IDX_W),
    .LVL_W  (LVL_W)
  ) u_build (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (build_acc),
    .drained_i  (!v1_q),
    .live_cnt_i (live_cnt),
    .ctl_o      (bctl),
    .rd_lvl_o   (b_rd_lvl),
    .rd_pos_a_o (b_pos_a),
    .rd_pos_b_o (b_pos_b),
    .wr_lvl_o   (b_wr_lvl),
    .wr_pos_o   (b_wr_pos)
  );

  // table memory: one write port, two registered read ports
  logic [VALUE_WIDTH-1:0] table_mem [DEPTH];
  logic [VALUE_WIDTH-1:0] rd_a_q;
  logic [VALUE_WIDTH-1:0] rd_b_q;
  logic                   rd_en;
  logic [AW-1:0]          rd_addr_a;
  logic [AW-1:0]          rd_addr_b;
  logic                   wr_en;
  logic [AW-1:0]          wr_addr;
  logic [VALUE_WIDTH-1:0] wr_data;
  logic [VALUE_WIDTH-1:0] min_val;

  assign min_val = ($signed(rd_b_q) < $signed(rd_a_q)) ? rd_b_q : rd_a_q;

  assign rd_en     = query_acc || bctl.rd_en;
  assign rd_addr_a = bctl.busy ? {b_rd_lvl, b_pos_a} : {LVL_W'(q_k), lo_w[IDX_W-1:0]};
  assign rd_addr_b = bctl.busy ? {b_rd_lvl, b_pos_b} : {LVL_W'(q_k), q_pos_b[IDX_W-1:0]};

  // loads and build writes never coincide: input is held off during a build
  assign wr_en   = load_acc || bctl.wr_en;
  assign wr_addr = bctl.wr_en ? {b_wr_lvl, b_wr_pos}
                              : {LVL_W'(0), IDX_W'(load_index_i)};
  assign wr_data = bctl.wr_en ? min_val : load_value_i[VALUE_WIDTH-1:0];

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      table_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_a_q <= table_mem[rd_addr_a];
      rd_b_q <= table_mem[rd_addr_b];
    end
  end

  // read stage and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (query_acc) begin
        v1_q <= 1'b1;
      end else if (adv) begin
        v1_q <= 1'b0;
      end
      if (adv) begin
        out_valid_q <= v1_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (query_acc) begin
      err1_q <= q_err;
    end
    if (adv && v1_q) begin
      range_error_q <= err1_q;
      minimum_q     <= err1_q ? '0
                              : strm_pkg::DATA_W'($signed(min_val));
    end
  end

  assign out_valid_o   = out_valid_q;
  assign minimum_o     = minimum_q;
  assign range_error_o = range_error_q;

  // checks
  `ASSERT_IMPL(a_wr_exclusive, bctl.wr_en, !load_acc, "build write collides with a load")
  `ASSERT_NEXT(a_query_staged, query_acc, v1_q, "accepted query missing from read stage")
  `ASSERT_IMPL(a_err_zero, out_valid_o && range_error_o, minimum_o == '0,
               "flagged range with nonzero minimum")
  `ASSERT_IMPL(a_build_drained, bctl.rd_en, !v1_q, "build read clobbers a pending query")

endmodule
